/* rtl/igs_pkg.sv */
package igs_pkg;

  localparam int RESULT_FRACTION_BITS = 16;

  localparam int LIFT = RESULT_FRACTION_BITS - 16;
  localparam int NSH  = (LIFT > 0) ? LIFT : 0;
  localparam int DSH  = (LIFT < 0) ? -LIFT : 0;

  localparam int AW  = 63;
  localparam int PW  = 126;
  localparam int SW  = 63;
  localparam int NW  = 63 + NSH;
  localparam int DW  = 31 + DSH;
  localparam int NHW = NW - 32;
  localparam int CW  = ((NHW > DW) ? NHW : DW) + 1;

  localparam int FRONT_STAGES = 4;
  localparam int MUL_STAGES   = 3;
  localparam int SQRT_STAGES  = SW;
  localparam int NORM_STAGES  = 3;
  localparam int SEL_STAGES   = 2;
  localparam int DIV_STAGES   = 33;
  localparam int LATENCY      = FRONT_STAGES + MUL_STAGES + SQRT_STAGES + NORM_STAGES
                                + SEL_STAGES + DIV_STAGES;

  typedef enum logic {
    REG_MEAN  = 1'b0,
    REG_SHAPE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [AW-1:0] a;
    logic [15:0]   u;
  } side_t;

endpackage

/* rtl/inverse_gaussian_sampler_top.sv */
// Wald variate generator, Michael-Schucany-Haas transform.
// Input: one item (normal_sample_i, Q3.12 signed; uniform_sample_i, Q0.16) is
// taken at each rising edge where start is high and busy is low. busy stays
// low, so an item may enter every cycle.
// Output: result_valid_o is high for one cycle per item, with wald_sample_o
// (Q16.16, or the configured fraction bits) and saturated_o, set when the
// value was clipped to all ones. The receiver cannot stall the block.
// Throughput: one item per cycle. The pipeline depth comes from the
// 63-stage square root, one root bit per stage, and the 33-stage divider,
// an input stage with the overflow check and then one quotient bit per
// stage, plus front multiplies, the wide multiplier, normalization and select.
// Configuration: cfg_we_i with cfg_idx_i (0 mean, 1 shape) and cfg_data_i
// writes a register at the clock edge; write only while no item is in flight.
// Reset: rst_ni clears all pipeline valid bits and sets mean and shape to 1.0.
module inverse_gaussian_sampler_top
  import igs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] normal_sample_i,
  input  logic [15:0] uniform_sample_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [31:0] wald_sample_o,
  output logic        saturated_o
);

  logic [31:0] mean_q, shape_q, mu_eff, lam_eff;
  logic        accept;

  logic        v0_q, v1_q, v2_q, v3_q;
  logic [16:0] mag_d, mag_q;
  logic [15:0] u0_q, u1_q, u2_q;
  logic [30:0] y_q;
  logic [AW-1:0] a_q, b_q, apb_q;
  side_t       side3_q;

  logic          mul_v;
  logic [PW-1:0] mul_prod;
  side_t         mul_side;
  logic          sq_v;
  logic [SW-1:0] sq_root;
  side_t         sq_side;

  logic        n1_v_q, n2_v_q, n3_v_q;
  logic [63:0] num1_d, den1_d, num1_q, den1_q, num2_q, den2_q;
  logic [15:0] un1_q, un2_q, un3_q;
  logic [5:0]  pos_d, sh_d, sh_q;
  logic [30:0] num3_q, den3_q;

  logic        sa_v_q, sb_v_q, acc_d, acc_q;
  logic [48:0] lhs_d;
  logic [48:0] rhs_d;
  logic [30:0] numa_q, dena_q, opnd_d;
  logic [62:0] p_q;
  logic [30:0] d_q;

  logic        div_v, div_sat;
  logic [31:0] div_quot;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= 32'h0001_0000;
      shape_q <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MEAN:  mean_q  <= cfg_data_i;
        REG_SHAPE: shape_q <= cfg_data_i;
        default:   mean_q  <= mean_q;
      endcase
    end
  end

  assign mu_eff  = (mean_q == '0) ? 32'd1 : mean_q;
  assign lam_eff = (shape_q == '0) ? 32'd1 : shape_q;

  assign mag_d = normal_sample_i[15] ? (17'd0 - {1'b1, normal_sample_i})
                                     : {1'b0, normal_sample_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      n1_v_q <= 1'b0;
      n2_v_q <= 1'b0;
      n3_v_q <= 1'b0;
      sa_v_q <= 1'b0;
      sb_v_q <= 1'b0;
    end else begin
      v0_q   <= accept;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      n1_v_q <= sq_v;
      n2_v_q <= n1_v_q;
      n3_v_q <= n2_v_q;
      sa_v_q <= n3_v_q;
      sb_v_q <= sa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    u0_q      <= uniform_sample_i;
    y_q       <= 31'({17'b0, mag_q} * {17'b0, mag_q});
    u1_q      <= u0_q;
    a_q       <= 63'({31'b0, mu_eff} * {32'b0, y_q});
    b_q       <= {5'b0, lam_eff, 26'b0};
    u2_q      <= u1_q;
    apb_q     <= a_q + b_q;
    side3_q.a <= a_q;
    side3_q.u <= u2_q;
  end

  igs_wmul u_wmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .side_i  (side3_q),
    .apb_i   (apb_q),
    .valid_o (mul_v),
    .prod_o  (mul_prod),
    .side_o  (mul_side)
  );

  igs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_v),
    .prod_i  (mul_prod),
    .side_i  (mul_side),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  always_comb begin
    if (sq_side.a == '0) begin
      num1_d = 64'd1;
      den1_d = 64'd1;
    end else begin
      num1_d = {1'b0, sq_root} - {1'b0, sq_side.a};
      den1_d = {1'b0, sq_root} + {1'b0, sq_side.a};
    end
  end

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < 64; i++) begin
      if (den1_q[i]) begin
        pos_d = 6'(i);
      end
    end
    sh_d = (pos_d >= 6'd31) ? (pos_d - 6'd30) : 6'd0;
  end

  assign lhs_d = {33'b0, un3_q} * ({17'b0, 1'b0, den3_q} + {17'b0, 1'b0, num3_q});
  assign rhs_d = {2'b0, den3_q, 16'b0};
  assign acc_d = lhs_d <= rhs_d;
  assign opnd_d = acc_q ? numa_q : dena_q;

  always_ff @(posedge clk_i) begin
    num1_q <= num1_d;
    den1_q <= den1_d;
    un1_q  <= sq_side.u;
    num2_q <= num1_q;
    den2_q <= den1_q;
    sh_q   <= sh_d;
    un2_q  <= un1_q;
    num3_q <= 31'(num2_q >> sh_q);
    den3_q <= 31'(den2_q >> sh_q);
    un3_q  <= un2_q;
    acc_q  <= acc_d;
    numa_q <= num3_q;
    dena_q <= den3_q;
    p_q    <= 63'({31'b0, mu_eff} * {32'b0, opnd_d});
    d_q    <= acc_q ? dena_q : numa_q;
  end

  igs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sb_v_q),
    .p_i     (p_q),
    .d_i     (d_q),
    .valid_o (div_v),
    .quot_o  (div_quot),
    .sat_o   (div_sat)
  );

  assign result_valid_o = div_v;
  assign wald_sample_o  = div_sat ? '1 : div_quot;
  assign saturated_o    = div_sat;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY result_valid_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, LATENCY))
    else $error("result without accepted item");

  a_div_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sb_v_q |-> ##DIV_STAGES result_valid_o)
    else $error("divider lost an item");

endmodule

/* rtl/igs_wmul.sv */
module igs_wmul
  import igs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  side_t         side_i,
  input  logic [AW-1:0] apb_i,
  output logic          valid_o,
  output logic [PW-1:0] prod_o,
  output side_t         side_o
);

  logic [2:0]  v_q;
  side_t       side1_q, side2_q, side3_q;
  logic [63:0] ll_q;
  logic [62:0] lh_q, hl_q;
  logic [61:0] hh1_q, hh2_q;
  logic [63:0] ll2_q;
  logic [63:0] mid_q;
  logic [PW-1:0] prod_q;

  logic [31:0] al, bl;
  logic [30:0] ah, bh;

  assign al = side_i.a[31:0];
  assign ah = side_i.a[62:32];
  assign bl = apb_i[31:0];
  assign bh = apb_i[62:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ll_q    <= {32'b0, al} * {32'b0, bl};
    lh_q    <= 63'({32'b0, al} * {33'b0, bh});
    hl_q    <= 63'({33'b0, ah} * {32'b0, bl});
    hh1_q   <= 62'({31'b0, ah} * {31'b0, bh});
    side1_q <= side_i;
    mid_q   <= {1'b0, lh_q} + {1'b0, hl_q};
    ll2_q   <= ll_q;
    hh2_q   <= hh1_q;
    side2_q <= side1_q;
    prod_q  <= {hh2_q, 64'b0} + {30'b0, mid_q, 32'b0} + {62'b0, ll2_q};
    side3_q <= side2_q;
  end

  assign valid_o = v_q[2];
  assign prod_o  = prod_q;
  assign side_o  = side3_q;

endmodule

/* rtl/igs_sqrt.sv */
module igs_sqrt
  import igs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [PW-1:0] prod_i,
  input  side_t         side_i,
  output logic          valid_o,
  output logic [SW-1:0] root_o,
  output side_t         side_o
);

  localparam int RW = PW + 1;

  logic [SW-1:0] v_q;
  logic [RW-1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  side_t         side_q [SW];

  for (genvar g = 0; g < SW; g++) begin : g_stage
    localparam int K = SW - 1 - g;
    logic          v_in;
    logic [RW-1:0] rem_in, trial, rem_d;
    logic [SW-1:0] root_in, root_d;
    side_t         side_in;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = {1'b0, prod_i};
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign trial = ({{(RW-SW){1'b0}}, root_in} << (K + 1)) | (RW'(1) << (2 * K));

    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (SW'(1) << K);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= rem_d;
      root_q[g] <= root_d;
      side_q[g] <= side_in;
    end
  end

  assign valid_o = v_q[SW-1];
  assign root_o  = root_q[SW-1];
  assign side_o  = side_q[SW-1];

endmodule

/* rtl/igs_div.sv */
module igs_div
  import igs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [62:0] p_i,
  input  logic [30:0] d_i,
  output logic        valid_o,
  output logic [31:0] quot_o,
  output logic        sat_o
);

  localparam int STEPS = DIV_STAGES - 1;

  logic [NW-1:0] num_full;
  logic [DW-1:0] den_full;
  logic [CW-1:0] nhi_ext, den_ext;
  logic          sat0_d;

  logic          v0_q, sat0_q;
  logic [DW-1:0] rem0_q, den0_q;
  logic [31:0]   nlo0_q;

  logic [STEPS-1:0] v_q;
  logic          sat_q [STEPS];
  logic [DW-1:0] rem_q [STEPS];
  logic [DW-1:0] den_q [STEPS];
  logic [31:0]   nlo_q [STEPS];
  logic [31:0]   quo_q [STEPS];

  assign num_full = {{NSH{1'b0}}, p_i} << NSH;
  assign den_full = {{DSH{1'b0}}, d_i} << DSH;
  assign nhi_ext  = CW'(num_full[NW-1:32]);
  assign den_ext  = CW'(den_full);
  assign sat0_d   = nhi_ext >= den_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sat0_q <= sat0_d;
    rem0_q <= nhi_ext[DW-1:0];
    den0_q <= den_full;
    nlo0_q <= num_full[31:0];
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic          v_in, sat_in;
    logic [DW-1:0] rem_in, den_in, rem_d;
    logic [31:0]   nlo_in, quo_in;
    logic [DW:0]   shifted;
    logic          bit_d;

    if (g == 0) begin : g_first
      assign v_in   = v0_q;
      assign sat_in = sat0_q;
      assign rem_in = rem0_q;
      assign den_in = den0_q;
      assign nlo_in = nlo0_q;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = v_q[g-1];
      assign sat_in = sat_q[g-1];
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign nlo_in = nlo_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    assign shifted = {rem_in, nlo_in[31]};
    assign bit_d   = shifted >= {1'b0, den_in};

    always_comb begin
      if (bit_d) begin
        rem_d = DW'(shifted - {1'b0, den_in});
      end else begin
        rem_d = shifted[DW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sat_q[g] <= sat_in;
      rem_q[g] <= rem_d;
      den_q[g] <= den_in;
      nlo_q[g] <= {nlo_in[30:0], 1'b0};
      quo_q[g] <= {quo_in[30:0], bit_d};
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign quot_o  = quo_q[STEPS-1];
  assign sat_o   = sat_q[STEPS-1];

endmodule
